// File: rtl/core/sactl_pkg.sv
// sactl_pkg: shared constants for the set-associative tag lookup unit
// default geometry and fixed port widths; no dependencies
package sactl_pkg;

  localparam int SETS_DEF   = 64;
  localparam int WAYS_DEF   = 4;
  localparam int BLK_W      = 32;
  localparam int WAY_OUT_W  = 2;
  localparam int LINE_OUT_W = 8;

endpackage

// File: rtl/core/sactl_ram.sv
// sactl_ram: generic single-port-write, single-port-read ram
// registered read data; no dependencies
module sactl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                     clk,
  input  logic                                     we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                         wdata,
  input  logic                                     re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// File: rtl/core/set_assoc_cache_tag_lookup_unit.sv
// set_assoc_cache_tag_lookup_unit: tag lookup with round-robin replacement
// one row per set in sactl_ram holds tags, valid bits and victim pointer
// depends on sactl_pkg and sactl_ram
// power-of-two SETS: set row read, then compare and write back; busy holds off a new
//   request until the result strobe goes out
// other SETS: reciprocal multiply for the tag, then the set from the remainder, then
//   set row read and compare; busy again holds off a new request until the result goes out
// reset clears the ram by a sweep over all SETS rows, busy stays high until it ends
// out_valid is high for one cycle per request; the receiver cannot stall
module set_assoc_cache_tag_lookup_unit #(
  parameter int SETS = sactl_pkg::SETS_DEF,
  parameter int WAYS = sactl_pkg::WAYS_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             start,
  output logic                             busy,
  input  logic [sactl_pkg::BLK_W-1:0]      in_block_number,
  output logic                             out_valid,
  output logic                             out_hit,
  output logic [sactl_pkg::WAY_OUT_W-1:0]  out_way,
  output logic [sactl_pkg::LINE_OUT_W-1:0] out_line_index
);

  localparam int  BLK_W    = sactl_pkg::BLK_W;
  localparam int  SET_W    = (SETS > 1) ? $clog2(SETS) : 1;
  localparam int  SET_LOG  = $clog2(SETS + 1) - 1;
  localparam int  SET_CEIL = (SETS > 1) ? $clog2(SETS) : 0;
  localparam int  TAG_W    = BLK_W - SET_LOG;
  localparam int  WAY_W    = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int  LINE_W   = (SETS * WAYS > 1) ? $clog2(SETS * WAYS) : 1;
  localparam int  ROW_W    = WAY_W + WAYS + WAYS * TAG_W;
  localparam bit  IS_POW2  = ((SETS & (SETS - 1)) == 0);
  localparam int  RES_LAT  = IS_POW2 ? 2 : 4;
  localparam logic [2*BLK_W-1:0] RECIP =
    (((2*BLK_W)'(1) << (BLK_W + SET_CEIL)) + (2*BLK_W)'(SETS - 1)) / (2*BLK_W)'(SETS);
  localparam logic [BLK_W-1:0] RECIP_LO = RECIP[BLK_W-1:0];

  typedef enum logic [4:0] {
    ST_CLR  = 5'b00001,
    ST_IDLE = 5'b00010,
    ST_DIV  = 5'b00100,
    ST_LOOK = 5'b01000,
    ST_CMP  = 5'b10000
  } state_t;

  state_t                  state_r, state_nxt;
  logic [SET_W-1:0]        clr_cnt_r, clr_cnt_nxt;
  logic [BLK_W-1:0]        quo_r, quo_nxt;
  logic [SET_W-1:0]        set_r, set_nxt;
  logic [TAG_W-1:0]        tag_r, tag_nxt;
  logic                    out_valid_r, out_valid_nxt;
  logic                    out_hit_r, out_hit_nxt;
  logic [sactl_pkg::WAY_OUT_W-1:0]  out_way_r, out_way_nxt;
  logic [sactl_pkg::LINE_OUT_W-1:0] out_line_r, out_line_nxt;

  logic                    accept;
  logic [2*BLK_W-1:0]      mul_lo;
  logic [2*BLK_W:0]        quo_prod;
  logic [BLK_W-1:0]        set_prod;
  logic [BLK_W-1:0]        rem_full;
  logic [SET_W-1:0]        rem_set;
  logic [SET_W-1:0]        in_set;

  logic                    ram_we;
  logic [SET_W-1:0]        ram_waddr;
  logic [ROW_W-1:0]        ram_wdata;
  logic                    ram_re;
  logic [SET_W-1:0]        ram_raddr;
  logic [ROW_W-1:0]        ram_rdata;

  logic [WAY_W-1:0]             rd_ptr;
  logic [WAYS-1:0]              rd_vld;
  logic [WAYS-1:0][TAG_W-1:0]   rd_tags;
  logic [WAY_W-1:0]             wr_ptr;
  logic [WAYS-1:0]              wr_vld;
  logic [WAYS-1:0][TAG_W-1:0]   wr_tags;
  logic                    hit_any;
  logic [WAY_W-1:0]        hit_way;
  logic                    free_any;
  logic [WAY_W-1:0]        free_way;
  logic [WAY_W-1:0]        chosen;
  logic [LINE_W-1:0]       line_full;

  assign busy   = (state_r != ST_IDLE);
  assign accept = start && !busy;
  assign in_set = SET_W'(in_block_number & BLK_W'(SETS - 1));

  // reciprocal is 2^BLK_W plus RECIP_LO, so the product is a shift plus a 32x32 multiply
  assign mul_lo   = (2*BLK_W)'(quo_r) * (2*BLK_W)'(RECIP_LO);
  assign quo_prod = {1'b0, quo_r, {BLK_W{1'b0}}} + {1'b0, mul_lo};
  assign set_prod = BLK_W'(tag_r) * BLK_W'(SETS);
  assign rem_full = quo_r - set_prod;
  assign rem_set  = SET_W'(rem_full);

  assign {rd_ptr, rd_vld, rd_tags} = ram_rdata;

  // lowest matching way, lowest free way
  always_comb begin
    hit_any  = 1'b0;
    hit_way  = '0;
    free_any = 1'b0;
    free_way = '0;
    for (int w = WAYS - 1; w >= 0; w--) begin
      if (rd_vld[w] && (rd_tags[w] == tag_r)) begin
        hit_any = 1'b1;
        hit_way = WAY_W'(w);
      end
      if (!rd_vld[w]) begin
        free_any = 1'b1;
        free_way = WAY_W'(w);
      end
    end
  end

  always_comb begin
    wr_ptr  = rd_ptr;
    wr_vld  = rd_vld;
    wr_tags = rd_tags;
    if (hit_any) begin
      chosen = hit_way;
    end else if (free_any) begin
      chosen = free_way;
    end else begin
      chosen = rd_ptr;
      wr_ptr = (rd_ptr == WAY_W'(WAYS - 1)) ? '0 : WAY_W'(rd_ptr + 1'b1);
    end
    wr_tags[chosen] = tag_r;
    wr_vld[chosen]  = 1'b1;
  end

  assign line_full = LINE_W'(LINE_W'(set_r) * LINE_W'(WAYS) + LINE_W'(chosen));

  always_comb begin
    state_nxt     = state_r;
    clr_cnt_nxt   = clr_cnt_r;
    quo_nxt       = quo_r;
    set_nxt       = set_r;
    tag_nxt       = tag_r;
    out_valid_nxt = 1'b0;
    out_hit_nxt   = out_hit_r;
    out_way_nxt   = out_way_r;
    out_line_nxt  = out_line_r;
    ram_we        = 1'b0;
    ram_waddr     = set_r;
    ram_wdata     = {wr_ptr, wr_vld, wr_tags};
    ram_re        = 1'b0;
    ram_raddr     = set_r;
    unique case (state_r)
      ST_CLR: begin
        ram_we      = 1'b1;
        ram_waddr   = clr_cnt_r;
        ram_wdata   = '0;
        clr_cnt_nxt = SET_W'(clr_cnt_r + 1'b1);
        if (clr_cnt_r == SET_W'(SETS - 1)) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        ram_re    = accept;
        ram_raddr = in_set;
        if (accept) begin
          set_nxt   = in_set;
          tag_nxt   = TAG_W'(in_block_number >> SET_LOG);
          quo_nxt   = in_block_number;
          state_nxt = IS_POW2 ? ST_CMP : ST_DIV;
        end
      end
      ST_DIV: begin
        tag_nxt   = TAG_W'(quo_prod >> (BLK_W + SET_CEIL));
        state_nxt = ST_LOOK;
      end
      ST_LOOK: begin
        ram_re    = 1'b1;
        ram_raddr = rem_set;
        set_nxt   = rem_set;
        state_nxt = ST_CMP;
      end
      ST_CMP: begin
        ram_we        = !hit_any;
        out_valid_nxt = 1'b1;
        out_hit_nxt   = hit_any;
        out_way_nxt   = sactl_pkg::WAY_OUT_W'(chosen);
        out_line_nxt  = sactl_pkg::LINE_OUT_W'(line_full);
        state_nxt     = ST_IDLE;
      end
      default: begin
        state_nxt = ST_CLR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLR;
      clr_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_cnt_r   <= clr_cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    quo_r      <= quo_nxt;
    set_r      <= set_nxt;
    tag_r      <= tag_nxt;
    out_hit_r  <= out_hit_nxt;
    out_way_r  <= out_way_nxt;
    out_line_r <= out_line_nxt;
  end

  sactl_ram #(
    .WIDTH(ROW_W),
    .DEPTH(SETS)
  ) u_row_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .re   (ram_re),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  assign out_valid      = out_valid_r;
  assign out_hit        = out_hit_r;
  assign out_way        = out_way_r;
  assign out_line_index = out_line_r;

  // every accepted request is followed by its result strobe
  a_req_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##RES_LAT out_valid)
    else $error("request without result");

  // one result per request, never two in a row
  a_single_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("repeated result strobe");

  // busy drops only when a result goes out or the clearing sweep ends
  a_busy_release: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(busy) |-> (out_valid || $past(state_r == ST_CLR)))
    else $error("busy released without result");

endmodule
